[sv/mstb_pkg.sv]
package mstb_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int FAST_END    = 6;
   localparam int MEDIUM_END  = 11;
   localparam int TIMER_WIDTH = 16;

   localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam int MEDIUM_DIV = 10;
   localparam int SLOW_DIV   = 100;

   // Reciprocal of 15 scaled by 2**20; exact for quotients up to the saturation point.
   localparam int RECIP_15   = 69906;
   localparam int MINUTE_SAT = 2048 * 60;

   typedef logic [TIMER_WIDTH-1:0] timer_type;

   localparam timer_type STOPPED = '1;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_SET   = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_QUERY = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_READ,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic hit;
   } report_ctl_type;

   function automatic timer_type step_down(timer_type v);
      if (v != '0 && v != STOPPED) begin
         return v - timer_type'(1);
      end
      return v;
   endfunction

   function automatic logic [15:0] units_of(timer_type v);
      if (34'(v) > 34'd65535) begin
         return 16'hFFFF;
      end
      return 16'(v);
   endfunction

   // Rounded-up division by 60: add 59, divide by 4 with a shift, then by 15
   // through the scaled reciprocal.
   function automatic logic [10:0] minutes_of(timer_type v);
      logic [33:0] x;
      logic [14:0] y;
      logic [31:0] p;
      x = 34'(v) + 34'd59;
      y = x[16:2];
      p = 32'(y) * 32'(RECIP_15);
      if (x >= 34'(MINUTE_SAT)) begin
         return 11'h7FF;
      end
      return p[30:20];
   endfunction

endpackage

[sv/mstb_channels.sv]
interface mstb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [3:0]  timer_index;
   logic [15:0] load_value;

   modport source (output valid, output command, output timer_index, output load_value,
                   input ready);
   modport sink   (input valid, input command, input timer_index, input load_value,
                   output ready);
endinterface

interface mstb_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_running;
   logic [15:0] units_left;
   logic [10:0] minutes_left;
   logic [15:0] tick_count;

   modport source (output valid, output is_running, output units_left,
                   output minutes_left, output tick_count, input ready);
   modport sink   (input valid, input is_running, input units_left,
                   input minutes_left, input tick_count, output ready);
endinterface

[sv/mstb_ram.sv]
module mstb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mstb_ctrl.sv]
module mstb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   mstb_req_if.sink                   req,
   input  logic                       slot_free,
   output logic                       wr_en,
   output logic [mstb_pkg::ADDR_W-1:0] wr_addr,
   output mstb_pkg::timer_type        wr_data,
   output logic                       rd_en,
   output logic [mstb_pkg::ADDR_W-1:0] rd_addr,
   input  mstb_pkg::timer_type        rd_data,
   output mstb_pkg::report_ctl_type   rpt,
   output logic [15:0]                tick_count
);
   import mstb_pkg::*;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       wb_addr_ff, wb_addr_in;
   logic                    pend_ff, pend_in;
   logic [3:0]              idx_ff, idx_in;
   logic                    med_due_ff, med_due_in;
   logic                    slow_due_ff, slow_due_in;
   logic [3:0]              med_pre_ff, med_pre_in;
   logic [6:0]              slow_pre_ff, slow_pre_in;
   logic [15:0]             tick_ff, tick_in;
   logic [NUM_TIMERS-1:0]   vld_ff, vld_in;

   logic                    req_hit;
   logic [3:0]              med_next;
   logic [6:0]              slow_next;
   timer_type               swept;
   int unsigned             wb_pos;

   assign req_hit = 32'(req.timer_index) < NUM_TIMERS;
   assign med_next  = med_pre_ff + 4'd1;
   assign slow_next = slow_pre_ff + 7'd1;
   assign wb_pos    = 32'(wb_addr_ff);

   // Fast, medium and slow steps cover disjoint index ranges, so an entry steps at most once.
   always_comb begin
      swept = vld_ff[wb_addr_ff] ? rd_data : '0;
      if (wb_pos < FAST_END) begin
         swept = step_down(swept);
      end
      if (med_due_ff && wb_pos >= FAST_END && wb_pos < MEDIUM_END) begin
         swept = step_down(swept);
      end
      if (slow_due_ff && wb_pos >= MEDIUM_END) begin
         swept = step_down(swept);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_ff     <= 1'b0;
         med_pre_ff  <= '0;
         slow_pre_ff <= '0;
         tick_ff     <= '0;
         vld_ff      <= '0;
         cnt_ff      <= '0;
         med_due_ff  <= 1'b0;
         slow_due_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         med_pre_ff  <= med_pre_in;
         slow_pre_ff <= slow_pre_in;
         tick_ff     <= tick_in;
         vld_ff      <= vld_in;
         cnt_ff      <= cnt_in;
         med_due_ff  <= med_due_in;
         slow_due_ff <= slow_due_in;
      end
      wb_addr_ff <= wb_addr_in;
      idx_ff     <= idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      wb_addr_in  = wb_addr_ff;
      pend_in     = 1'b0;
      idx_in      = idx_ff;
      med_due_in  = med_due_ff;
      slow_due_in = slow_due_ff;
      med_pre_in  = med_pre_ff;
      slow_pre_in = slow_pre_ff;
      tick_in     = tick_ff;
      vld_in      = vld_ff;
      req.ready   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = wb_addr_ff;
      wr_data     = swept;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff;
      rpt.load    = 1'b0;
      rpt.hit     = (32'(idx_ff) < NUM_TIMERS) && vld_ff[ADDR_W'(idx_ff)];

      // A swept entry comes back from the memory in the cycle after its read.
      if (pend_ff && vld_ff[wb_addr_ff]) begin
         wr_en = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            // Ready is high throughout this state, so valid alone marks an accepted item.
            if (req.valid) begin
               idx_in = req.timer_index;
               state_in = ST_READ;
               unique case (command_type'(req.command))
                  CMD_TICK: begin
                     med_due_in  = med_next >= 4'(MEDIUM_DIV);
                     med_pre_in  = (med_next >= 4'(MEDIUM_DIV)) ? 4'd0 : med_next;
                     slow_due_in = slow_next >= 7'(SLOW_DIV);
                     slow_pre_in = (slow_next >= 7'(SLOW_DIV)) ? 7'd0 : slow_next;
                     tick_in     = tick_ff + 16'd1;
                     cnt_in      = '0;
                     state_in    = ST_SWEEP;
                  end
                  CMD_SET, CMD_STOP: begin
                     if (req_hit) begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(req.timer_index);
                        wr_data = (command_type'(req.command) == CMD_SET) ?
                                  timer_type'(req.load_value) : STOPPED;
                        vld_in[ADDR_W'(req.timer_index)] = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            rd_en      = 1'b1;
            rd_addr    = cnt_ff;
            pend_in    = 1'b1;
            wb_addr_in = cnt_ff;
            cnt_in     = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(NUM_TIMERS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(idx_ff);
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (slot_free) begin
               rpt.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign tick_count = tick_ff;

endmodule

[sv/mstb_report.sv]
module mstb_report (
   input  logic                      clock,
   input  logic                      reset,
   input  mstb_pkg::report_ctl_type  rpt,
   input  mstb_pkg::timer_type       rd_data,
   input  logic [15:0]               tick_count,
   output logic                      slot_free,
   mstb_rsp_if.source                rsp
);
   import mstb_pkg::*;

   logic        valid_ff, valid_in;
   logic        running_ff, running_in;
   logic [15:0] units_ff, units_in;
   logic [10:0] minutes_ff, minutes_in;
   logic [15:0] tick_ff, tick_in;
   timer_type   v;

   assign slot_free = !valid_ff || rsp.ready;

   always_comb begin
      v          = rpt.hit ? rd_data : '0;
      valid_in   = valid_ff && !rsp.ready;
      running_in = running_ff;
      units_in   = units_ff;
      minutes_in = minutes_ff;
      tick_in    = tick_ff;
      if (rpt.load) begin
         valid_in   = 1'b1;
         running_in = (v != '0) && (v != STOPPED);
         units_in   = (v == STOPPED) ? 16'd0 : units_of(v);
         minutes_in = (v == STOPPED) ? 11'd0 : minutes_of(v);
         tick_in    = tick_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      running_ff <= running_in;
      units_ff   <= units_in;
      minutes_ff <= minutes_in;
      tick_ff    <= tick_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.is_running   = running_ff;
   assign rsp.units_left   = units_ff;
   assign rsp.minutes_left = minutes_ff;
   assign rsp.tick_count   = tick_ff;

endmodule

[sv/multirate_software_timer_bank.sv]
// Bank of down-counting timers in three rate groups (every tick, every 10th
// tick, every 100th tick), held in one single-port-read memory. Every item
// returns one result describing the addressed timer after the command. A set,
// stop or query item goes through the read and report states until the block
// is ready again; a tick item walks all NUM_TIMERS entries through one
// decrementer, one entry a cycle, then goes through drain, read and report.
// A further item is accepted once the result of the previous one has reached
// the output register, even while that result still waits to be taken.
module multirate_software_timer_bank (
   input  logic       clock,
   input  logic       reset,
   mstb_req_if.sink   req_chan,
   mstb_rsp_if.source rsp_chan
);
   import mstb_pkg::*;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   timer_type         wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   timer_type         rd_data;
   report_ctl_type    rpt;
   logic              slot_free;
   logic [15:0]       tick_count;

   mstb_ram #(
      .WIDTH (TIMER_WIDTH),
      .DEPTH (1 << ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mstb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .slot_free  (slot_free),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rpt        (rpt),
      .tick_count (tick_count)
   );

   mstb_report u_report (
      .clock      (clock),
      .reset      (reset),
      .rpt        (rpt),
      .rd_data    (rd_data),
      .tick_count (tick_count),
      .slot_free  (slot_free),
      .rsp        (rsp_chan)
   );

   // The sweep never reads the entry it is writing back in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en && wr_addr == rd_addr))
      else $error("memory read and write hit the same entry");

   // Only one item is in progress at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("item accepted while another is in progress");

   // A result is only loaded into a free output slot and then shows as valid.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rpt.load |-> slot_free)
      else $error("result loaded over one not yet taken");

   a_load_shown: assert property (@(posedge clock) disable iff (reset)
      rpt.load |=> rsp_chan.valid)
      else $error("loaded result not presented");

endmodule

[sim/tb_multirate_software_timer_bank.sv]
module tb_multirate_software_timer_bank;
   timeunit 1ns;
   timeprecision 1ps;

   import mstb_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int HOLD_AT_ITEM  = 500;
   localparam int HOLD_CYCLES   = 500;
   localparam int DRAIN_CYCLES  = NUM_TIMERS + 24;

   typedef struct {
      logic        running;
      logic [15:0] units;
      logic [10:0] minutes;
      logic [15:0] ticks;
   } timer_report_type;

   // Keeps a private copy of the bank and the queue of reports it predicts.
   class timer_report_book;
      timer_type        counts [NUM_TIMERS];
      logic [3:0]       medium_phase;
      logic [6:0]       slow_phase;
      logic [15:0]      base_ticks;
      timer_report_type reports_due [$];
      int               errors;
      int               checked;
      int               slow_steps;
      int               cmd_seen [4];

      function new();
         foreach (counts[i]) counts[i] = '0;
         medium_phase = '0;
         slow_phase   = '0;
         base_ticks   = '0;
         errors       = 0;
         checked      = 0;
         slow_steps   = 0;
         foreach (cmd_seen[i]) cmd_seen[i] = 0;
      endfunction

      function void count_down_range(int lo, int hi);
         int first;
         int last;
         first = (lo > NUM_TIMERS) ? NUM_TIMERS : lo;
         last  = (hi > NUM_TIMERS) ? NUM_TIMERS : hi;
         for (int i = first; i < last; i++) begin
            if (counts[i] != '0 && counts[i] != STOPPED) begin
               counts[i] = counts[i] - timer_type'(1);
            end
         end
      endfunction

      function void predict_report(command_type cmd, logic [3:0] idx, logic [15:0] load);
         timer_type        v;
         longint           mins;
         logic             in_bank;
         timer_report_type r;
         in_bank = int'(idx) < NUM_TIMERS;
         cmd_seen[int'(cmd)]++;
         case (cmd)
            CMD_TICK: begin
               count_down_range(0, FAST_END);
               medium_phase = medium_phase + 4'd1;
               if (int'(medium_phase) >= MEDIUM_DIV) begin
                  medium_phase = '0;
                  count_down_range(FAST_END, MEDIUM_END);
               end
               slow_phase = slow_phase + 7'd1;
               if (int'(slow_phase) >= SLOW_DIV) begin
                  slow_phase = '0;
                  slow_steps++;
                  count_down_range(MEDIUM_END, NUM_TIMERS);
               end
               base_ticks = base_ticks + 16'd1;
            end
            CMD_SET: begin
               if (in_bank) counts[idx] = timer_type'(load);
            end
            CMD_STOP: begin
               if (in_bank) counts[idx] = STOPPED;
            end
            default: ;
         endcase
         v = in_bank ? counts[idx] : timer_type'(0);
         if (v == STOPPED) begin
            r.running = 1'b0;
            r.units   = '0;
            r.minutes = '0;
         end else begin
            mins      = (longint'(v) + 59) / 60;
            r.running = (v != '0);
            r.units   = (longint'(v) > 65535) ? 16'hFFFF : 16'(v);
            r.minutes = (mins > 2047) ? 11'h7FF : 11'(mins);
         end
         r.ticks = base_ticks;
         reports_due.push_back(r);
      endfunction

      function void compare_report(timer_report_type got);
         timer_report_type want;
         if (reports_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("[%0t] unexpected result: running=%0b units=%0d minutes=%0d",
                        $realtime, got.running, got.units, got.minutes);
               $display("   ticks=%0d", got.ticks);
            end
            return;
         end
         want = reports_due.pop_front();
         checked++;
         if (got.running !== want.running || got.units !== want.units ||
             got.minutes !== want.minutes || got.ticks !== want.ticks) begin
            errors++;
            if (errors <= 10) begin
               $display("[%0t] mismatch (expected/actual): running %0b/%0b units %0d/%0d",
                        $realtime, want.running, got.running, want.units, got.units);
               $display("   minutes %0d/%0d ticks %0d/%0d",
                        want.minutes, got.minutes, want.ticks, got.ticks);
            end
         end
      endfunction

      function int pending();
         return reports_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   mstb_req_if req_bus ();
   mstb_rsp_if rsp_bus ();

   multirate_software_timer_bank DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   timer_report_book book = new();
   int items_in   = 0;
   int burst_left = 0;
   int cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("Run exceeded %0d cycles with %0d results outstanding.", CYCLE_LIMIT,
                     book.pending());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Samples both handshakes on the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      timer_report_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            book.predict_report(command_type'(req_bus.command), req_bus.timer_index,
                                req_bus.load_value);
            items_in++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.running = rsp_bus.is_running;
            got.units   = rsp_bus.units_left;
            got.minutes = rsp_bus.minutes_left;
            got.ticks   = rsp_bus.tick_count;
            book.compare_report(got);
         end
      end
   end

   // The receiver wanders between stall patterns and holds off once for a long stretch.
   initial begin : receiver
      int mode;
      int mode_left;
      int hold_left;
      bit hold_done;
      mode      = 0;
      mode_left = 60;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_in >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ~rsp_bus.ready;
            endcase
         end
      end
   end

   task automatic send_item(input command_type cmd, input logic [3:0] idx,
                            input logic [15:0] load);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.timer_index <= idx;
      req_bus.load_value  <= load;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   initial begin : stimulus
      int          pick;
      command_type cmd;
      logic [3:0]  idx;
      logic [15:0] load;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_TICK;
      req_bus.timer_index = '0;
      req_bus.load_value  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset state, group edges, sentinel loads, ignored fields, medium wrap.
      send_item(CMD_QUERY, 4'd0,  16'h0000);
      send_item(CMD_QUERY, 4'd15, 16'hFFFF);
      send_item(CMD_SET,   4'd0,  16'd1);
      send_item(CMD_SET,   4'd5,  16'd60);
      send_item(CMD_SET,   4'd6,  16'd61);
      send_item(CMD_SET,   4'd10, 16'd65534);
      send_item(CMD_SET,   4'd11, 16'd120);
      send_item(CMD_SET,   4'd15, 16'd59);
      send_item(CMD_SET,   4'd3,  16'hFFFF);
      send_item(CMD_SET,   4'd4,  16'd0);
      send_item(CMD_TICK,  4'd0,  16'hFFFF);
      send_item(CMD_TICK,  4'd5,  16'h5A5A);
      send_item(CMD_STOP,  4'd6,  16'h1234);
      send_item(CMD_QUERY, 4'd6,  16'hFFFF);
      send_item(CMD_QUERY, 4'd10, 16'hFFFF);
      send_item(CMD_SET,   4'd7,  16'd2);
      repeat (9) send_item(CMD_TICK, 4'd7, 16'hA5A5);

      // Random part: mostly meaningful traffic with small counts so timers expire,
      // plus a share of fully random items.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idx  = 4'($urandom_range(0, 15));
         load = 16'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            cmd = CMD_TICK;
         end else if (pick < 65) begin
            cmd = CMD_SET;
            case ($urandom_range(0, 9))
               0: load = 16'd0;
               1: load = 16'hFFFF;
               2: load = 16'hFFFE;
               3: load = 16'($urandom_range(1, 3));
               4: load = 16'($urandom_range(59, 61));
               5: load = 16'($urandom_range(119, 121));
               6, 7: load = 16'($urandom_range(1, 300));
               default: ;
            endcase
         end else if (pick < 75) begin
            cmd = CMD_STOP;
         end else if (pick < 92) begin
            cmd = CMD_QUERY;
         end else begin
            cmd = command_type'($urandom_range(0, 3));
         end
         send_item(cmd, idx, load);
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (book.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items: %0d ticks, %0d sets, %0d stops, %0d queries.",
               items_in, book.cmd_seen[0], book.cmd_seen[1], book.cmd_seen[2],
               book.cmd_seen[3]);
      $display("%0d results checked; slow group stepped %0d times; one output hold-off",
               book.checked, book.slow_steps);
      $display("of %0d cycles; %0d mismatches.", HOLD_CYCLES, book.errors);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
